// ===== design/nsc_pkg.sv =====
// Shared types, codes and character tables for the NMEA sentence checksum checker.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package nsc_pkg;

  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_STAR   = 8'h2A;
  localparam logic [7:0] CHAR_NUL    = 8'h00;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_F = 8'h46;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_F = 8'h66;
  localparam logic [7:0] HEX_TEN     = 8'h0A;

  localparam int unsigned HdrLen = 5;

  localparam logic [1:0] KIND_OTHER = 2'd0;
  localparam logic [1:0] KIND_GGA   = 2'd1;
  localparam logic [1:0] KIND_RMC   = 2'd2;

  localparam logic [1:0] TALKER_OTHER = 2'd0;
  localparam logic [1:0] TALKER_GP    = 2'd1;
  localparam logic [1:0] TALKER_GN    = 2'd2;

  localparam logic [0:0] REG_GPS     = 1'b0;
  localparam logic [0:0] REG_GLONASS = 1'b1;

  typedef struct packed {
    logic gps_en;
    logic glonass_en;
  } nsc_cfg_t;

  typedef struct packed {
    logic [1:0] sentence_kind;
    logic [1:0] talker_kind;
    logic       checksum_ok;
    logic [7:0] received_checksum;
    logic [7:0] computed_checksum;
    logic       ended_early;
  } nsc_result_t;

  // Header text: 0 GPGGA, 1 GNGGA, 2 GPRMC, 3 GNRMC
  function automatic logic [7:0] hdr_char(input logic [1:0] k, input logic [2:0] pos);
    logic [7:0] c;
    begin
      case (pos)
        3'd0:    c = 8'h47;
        3'd1:    c = k[0] ? 8'h4E : 8'h50;
        3'd2:    c = k[1] ? 8'h52 : 8'h47;
        3'd3:    c = k[1] ? 8'h4D : 8'h47;
        3'd4:    c = k[1] ? 8'h43 : 8'h41;
        default: c = 8'h00;
      endcase
      return c;
    end
  endfunction

  // Hex digit value; anything that is not a hex letter decodes as byte - '0'
  function automatic logic [7:0] digit_value(input logic [7:0] c);
    logic [7:0] v;
    begin
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
        v = c - CHAR_UPPER_A + HEX_TEN;
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
        v = c - CHAR_LOWER_A + HEX_TEN;
      end else begin
        v = c - CHAR_ZERO;
      end
      return v;
    end
  endfunction

endpackage

`default_nettype wire

// ===== design/nmea_sentence_checksum_checker.sv =====
// Top level of the NMEA sentence checksum checker: APB registers and pipeline.
// Depends on nsc_pkg, nsc_in_stage, nsc_parser and nsc_out_stage.
`timescale 1ns / 1ps
`default_nettype none

// Takes one character word per cycle on the input channel. A '$' opens a
// sentence, bytes up to '*' are XORed and the first five are matched against
// GPGGA, GNGGA, GPRMC and GNRMC; the two bytes after '*' are the received
// checksum. One result word is given per finished sentence (after the low
// digit, or on a NUL before '*'). Throughput is one word per cycle while no
// result waits untaken. A result is registered: the word that finishes it is
// first held in the input register, and the parser then loads the result
// register once it is free. While a result waits untaken, the input stalls.
// Registers: 0x0 bit 0 enables GP talker recognition, 0x4 bit 0 enables GN;
// both reset to 1; user writes only while the block is idle (not enforced).
module nmea_sentence_checksum_checker
  import nsc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  output logic [1:0]       sentence_kind_o,
  output logic [1:0]       talker_kind_o,
  output logic             checksum_ok_o,
  output logic [7:0]       received_checksum_o,
  output logic [7:0]       computed_checksum_o,
  output logic             ended_early_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  nsc_cfg_t    cfg_q;
  logic        cfg_wr;
  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        out_free;
  logic        advance;
  logic        res_valid;
  nsc_result_t res;
  nsc_result_t out_res;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gps_en     <= 1'b1;
      cfg_q.glonass_en <= 1'b1;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_GPS:     cfg_q.gps_en     <= pwdata[0];
        REG_GLONASS: cfg_q.glonass_en <= pwdata[0];
        default:     cfg_q.gps_en     <= cfg_q.gps_en;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_GPS:     prdata[0] = cfg_q.gps_en;
      REG_GLONASS: prdata[0] = cfg_q.glonass_en;
      default:     prdata    = '0;
    endcase
  end

  assign advance = s1_valid && out_free;

  nsc_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .data_byte_i(data_byte_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .advance_i  (advance),
    .valid_o    (s1_valid),
    .byte_o     (s1_byte)
  );

  nsc_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .byte_i     (s1_byte),
    .cfg_i      (cfg_q),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  nsc_out_stage u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (advance),
    .res_valid_i(res_valid),
    .res_i      (res),
    .out_ready_i(out_ready_i),
    .out_valid_o(out_valid_o),
    .free_o     (out_free),
    .res_o      (out_res)
  );

  assign sentence_kind_o     = out_res.sentence_kind;
  assign talker_kind_o       = out_res.talker_kind;
  assign checksum_ok_o       = out_res.checksum_ok;
  assign received_checksum_o = out_res.received_checksum;
  assign computed_checksum_o = out_res.computed_checksum;
  assign ended_early_o       = out_res.ended_early;

  a_early_fails: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ended_early_o |-> !checksum_ok_o && received_checksum_o == 8'h00)
    else $error("early end with checksum fields set");

  a_ok_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && checksum_ok_o |-> received_checksum_o == computed_checksum_o)
    else $error("checksum_ok without matching checksums");

  a_kind_talker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (sentence_kind_o == KIND_OTHER) == (talker_kind_o == TALKER_OTHER))
    else $error("sentence kind and talker disagree");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

endmodule

`default_nettype wire

// ===== design/nsc_in_stage.sv =====
// Input register: holds one received word until the parser consumes it.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module nsc_in_stage (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic       advance_i,
  output logic            valid_o,
  output logic [7:0]      byte_o
);

  logic       valid_q;
  logic [7:0] byte_q;

  assign in_ready_o = !valid_q || advance_i;
  assign valid_o    = valid_q;
  assign byte_o     = byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= data_byte_i;
    end
  end

endmodule

`default_nettype wire

// ===== design/nsc_parser.sv =====
// Sentence state machine: running XOR, header match and checksum digit decode.
// Depends on nsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nsc_parser
  import nsc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        step_i,
  input  wire logic [7:0]  byte_i,
  input  wire nsc_cfg_t    cfg_i,
  output logic             res_valid_o,
  output nsc_result_t      res_o
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_BODY = 2'd1;
  localparam logic [1:0] PH_HIGH = 2'd2;
  localparam logic [1:0] PH_LOW  = 2'd3;

  logic [1:0] phase_q, phase_d;
  logic [2:0] pos_q, pos_d;
  logic [3:0] flags_q, flags_d;
  logic [7:0] xor_q, xor_d;
  logic [3:0] high_q, high_d;

  logic       emit;
  logic       early;
  logic [7:0] dig;
  logic [7:0] rx;
  logic [1:0] kind;
  logic [1:0] talker;

  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    flags_d = flags_q;
    xor_d   = xor_q;
    high_d  = high_q;
    emit    = 1'b0;
    early   = 1'b0;
    dig     = digit_value(byte_i);
    rx      = {high_q, 4'b0} | dig;
    unique case (phase_q)
      PH_BODY: begin
        if (byte_i == CHAR_DOLLAR) begin
          pos_d   = '0;
          flags_d = '1;
          xor_d   = '0;
        end else if (byte_i == CHAR_NUL) begin
          emit    = 1'b1;
          early   = 1'b1;
          phase_d = PH_IDLE;
        end else if (byte_i == CHAR_STAR) begin
          phase_d = PH_HIGH;
        end else begin
          xor_d = xor_q ^ byte_i;
          if (pos_q < 3'(HdrLen)) begin
            for (int k = 0; k < 4; k++) begin
              if (hdr_char(2'(k), pos_q) != byte_i) begin
                flags_d[k] = 1'b0;
              end
            end
            pos_d = pos_q + 3'd1;
          end
        end
      end
      PH_HIGH: begin
        high_d  = dig[3:0];
        phase_d = PH_LOW;
      end
      PH_LOW: begin
        emit    = 1'b1;
        phase_d = PH_IDLE;
      end
      default: begin
        if (byte_i == CHAR_DOLLAR) begin
          phase_d = PH_BODY;
          pos_d   = '0;
          flags_d = '1;
          xor_d   = '0;
        end
      end
    endcase
  end

  always_comb begin
    kind   = KIND_OTHER;
    talker = TALKER_OTHER;
    if (pos_q >= 3'(HdrLen)) begin
      if (flags_q[0] && cfg_i.gps_en) begin
        kind = KIND_GGA;  talker = TALKER_GP;
      end else if (flags_q[1] && cfg_i.glonass_en) begin
        kind = KIND_GGA;  talker = TALKER_GN;
      end else if (flags_q[2] && cfg_i.gps_en) begin
        kind = KIND_RMC;  talker = TALKER_GP;
      end else if (flags_q[3] && cfg_i.glonass_en) begin
        kind = KIND_RMC;  talker = TALKER_GN;
      end
    end
  end

  assign res_valid_o             = step_i && emit;
  assign res_o.sentence_kind     = kind;
  assign res_o.talker_kind       = talker;
  assign res_o.checksum_ok       = !early && (rx == xor_q);
  assign res_o.received_checksum = early ? 8'h00 : rx;
  assign res_o.computed_checksum = xor_q;
  assign res_o.ended_early       = early;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      pos_q   <= '0;
      flags_q <= '1;
      xor_q   <= '0;
      high_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      flags_q <= flags_d;
      xor_q   <= xor_d;
      high_q  <= high_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/nsc_out_stage.sv =====
// Result register: holds one finished sentence word until the sink takes it.
// Depends on nsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nsc_out_stage
  import nsc_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         load_i,
  input  wire logic         res_valid_i,
  input  wire nsc_result_t  res_i,
  input  wire logic         out_ready_i,
  output logic              out_valid_o,
  output logic              free_o,
  output nsc_result_t       res_o
);

  logic        valid_q;
  nsc_result_t res_q;

  assign free_o      = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= res_valid_i;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && res_valid_i) begin
      res_q <= res_i;
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for nmea_sentence_checksum_checker: byte words in, one result
// word per finished sentence out, talker enables over the APB port.
// Depends on nsc_pkg and the checker RTL.
`timescale 1ns / 1ps

module tb;
  import nsc_pkg::*;

  localparam int unsigned PHASE_WORDS   = 500;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned STALL_LIMIT   = 3000;
  localparam logic [2:0]  ADDR_GPS      = {REG_GPS, 2'b00};
  localparam logic [2:0]  ADDR_GLONASS  = {REG_GLONASS, 2'b00};

  typedef enum logic [1:0] {SCAN_IDLE, SCAN_BODY, SCAN_HIGH, SCAN_LOW} scan_phase_e;
  typedef enum int {DIG_UPPER, DIG_LOWER, DIG_WRONG, DIG_ANY} digit_style_e;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic [7:0]  data_byte = 8'h00;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic [1:0]  sentence_kind;
  logic [1:0]  talker_kind;
  logic        checksum_ok;
  logic [7:0]  rx_sum;
  logic [7:0]  calc_sum;
  logic        ended_early;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [2:0]  paddr     = 3'd0;
  logic [31:0] pwdata    = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  nmea_sentence_checksum_checker u_top (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .data_byte_i         (data_byte),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready),
    .sentence_kind_o     (sentence_kind),
    .talker_kind_o       (talker_kind),
    .checksum_ok_o       (checksum_ok),
    .received_checksum_o (rx_sum),
    .computed_checksum_o (calc_sum),
    .ended_early_o       (ended_early),
    .out_valid_o         (out_valid),
    .out_ready_i         (out_ready),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  always #5 clk = ~clk;

  // sentence tracker state
  scan_phase_e scan_phase = SCAN_IDLE;
  int unsigned hdr_seen   = 0;
  logic [3:0]  hdr_live   = 4'hF;
  logic [7:0]  xor_acc    = 8'h00;
  logic [7:0]  hi_digit   = 8'h00;
  logic        cfg_gps    = 1'b1;
  logic        cfg_gn     = 1'b1;
  nsc_result_t sentence_q[$];

  logic [7:0]  byte_q[$];
  bit          in_fire = 1'b0;
  bit          out_fire = 1'b0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  logic [31:0] rx_cycle = 0;
  int unsigned hold_left = 0;
  bit          hold_request = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned stall_cycles = 0;
  int unsigned errors = 0;
  int unsigned n_words = 0, n_results = 0, n_ok = 0, n_early = 0, n_gga = 0, n_rmc = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    if (errors <= 40)
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
  endtask

  // 0 GPGGA, 1 GNGGA, 2 GPRMC, 3 GNRMC
  function automatic logic [7:0] header_char(input int unsigned k, input int unsigned pos);
    logic [39:0] txt;
    case (k)
      0:       txt = "GPGGA";
      1:       txt = "GNGGA";
      2:       txt = "GPRMC";
      default: txt = "GNRMC";
    endcase
    return txt[8*(4-pos) +: 8];
  endfunction

  // non-hex bytes wrap as byte - '0'
  function automatic logic [7:0] nibble_of(input logic [7:0] c);
    if (c >= "a" && c <= "f") return c - "a" + 8'd10;
    if (c >= "A" && c <= "F") return c - "A" + 8'd10;
    return c - "0";
  endfunction

  task automatic close_sentence(input logic early, input logic [7:0] rx);
    nsc_result_t r;
    r = '0;
    if (hdr_seen >= HdrLen) begin
      if (hdr_live[0] && cfg_gps) begin
        r.sentence_kind = KIND_GGA; r.talker_kind = TALKER_GP;
      end else if (hdr_live[1] && cfg_gn) begin
        r.sentence_kind = KIND_GGA; r.talker_kind = TALKER_GN;
      end else if (hdr_live[2] && cfg_gps) begin
        r.sentence_kind = KIND_RMC; r.talker_kind = TALKER_GP;
      end else if (hdr_live[3] && cfg_gn) begin
        r.sentence_kind = KIND_RMC; r.talker_kind = TALKER_GN;
      end
    end
    r.checksum_ok       = !early && (rx == xor_acc);
    r.received_checksum = early ? 8'h00 : rx;
    r.computed_checksum = xor_acc;
    r.ended_early       = early;
    sentence_q.push_back(r);
  endtask

  task automatic track_char(input logic [7:0] b);
    case (scan_phase)
      SCAN_BODY: begin
        if (b == CHAR_DOLLAR) begin
          hdr_seen = 0; hdr_live = 4'hF; xor_acc = 8'h00;
        end else if (b == CHAR_NUL) begin
          close_sentence(1'b1, 8'h00);
          scan_phase = SCAN_IDLE;
        end else if (b == CHAR_STAR) begin
          scan_phase = SCAN_HIGH;
        end else begin
          xor_acc ^= b;
          if (hdr_seen < HdrLen) begin
            for (int k = 0; k < 4; k++)
              if (header_char(k, hdr_seen) != b) hdr_live[k] = 1'b0;
            hdr_seen++;
          end
        end
      end
      SCAN_HIGH: begin
        hi_digit   = nibble_of(b);
        scan_phase = SCAN_LOW;
      end
      SCAN_LOW: begin
        close_sentence(1'b0, {hi_digit[3:0], 4'h0} | nibble_of(b));
        scan_phase = SCAN_IDLE;
      end
      default: begin
        if (b == CHAR_DOLLAR) begin
          scan_phase = SCAN_BODY; hdr_seen = 0; hdr_live = 4'hF; xor_acc = 8'h00;
        end
      end
    endcase
  endtask

  // sender: bursts of random length, random gaps
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_fire)) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (byte_q.size() != 0) begin
        in_valid  <= 1'b1;
        data_byte <= byte_q.pop_front();
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 60);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern switches with bits 8:7 of its cycle counter, plus one long hold-off
  always @(negedge clk) begin
    rx_cycle++;
    if (hold_request && !hold_done) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (rx_cycle[8:7])
        2'd0:    out_ready <= 1'b1;
        2'd1:    out_ready <= ($urandom_range(0, 1) == 1);
        2'd2:    out_ready <= (rx_cycle[1:0] == 2'b00);
        default: out_ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  always @(posedge clk) begin : mon
    nsc_result_t want;
    bit          reg_fire;
    in_fire  = rst_n && in_valid && in_ready;
    out_fire = rst_n && out_valid && out_ready;
    reg_fire = rst_n && psel && penable && pready;
    if (out_fire) begin
      if (sentence_q.size() == 0) begin
        report_mismatch("result word with none expected", 0, 0);
      end else begin
        want = sentence_q.pop_front();
        n_results++;
        if (sentence_kind !== want.sentence_kind)
          report_mismatch("sentence_kind", sentence_kind, want.sentence_kind);
        if (talker_kind !== want.talker_kind)
          report_mismatch("talker_kind", talker_kind, want.talker_kind);
        if (checksum_ok !== want.checksum_ok)
          report_mismatch("checksum_ok", checksum_ok, want.checksum_ok);
        if (rx_sum !== want.received_checksum)
          report_mismatch("received_checksum", rx_sum, want.received_checksum);
        if (calc_sum !== want.computed_checksum)
          report_mismatch("computed_checksum", calc_sum, want.computed_checksum);
        if (ended_early !== want.ended_early)
          report_mismatch("ended_early", ended_early, want.ended_early);
        if (want.checksum_ok) n_ok++;
        if (want.ended_early) n_early++;
        if (want.sentence_kind == KIND_GGA) n_gga++;
        if (want.sentence_kind == KIND_RMC) n_rmc++;
      end
    end
    if (in_fire) begin
      n_words++;
      track_char(data_byte);
    end
    if (reg_fire && pwrite) begin
      case (paddr)
        ADDR_GPS:     cfg_gps = pwdata[0];
        ADDR_GLONASS: cfg_gn  = pwdata[0];
        default: ;
      endcase
    end
    if (in_fire || out_fire || reg_fire) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no progress for %0d cycles, %0d results outstanding",
               stall_cycles, sentence_q.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic reg_access(input logic [2:0] addr, input logic wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= wr; paddr <= addr; pwdata <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic read_check(input logic [2:0] addr, input logic want);
    logic [31:0] rd;
    reg_access(addr, 1'b0, 32'd0, rd);
    if (rd[0] !== want) report_mismatch("register readback", rd[0], want);
  endtask

  task automatic set_talkers(input logic gps, input logic gn);
    logic [31:0] rd;
    reg_access(ADDR_GPS, 1'b1, {31'd0, gps}, rd);
    reg_access(ADDR_GLONASS, 1'b1, {31'd0, gn}, rd);
    read_check(ADDR_GPS, gps);
    read_check(ADDR_GLONASS, gn);
  endtask

  // idle only once every result is in and trailing words have cleared the pipe
  task automatic wait_drained();
    while (byte_q.size() != 0 || in_valid || sentence_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] v, input bit lower);
    if (v < 4'd10) return "0" + v;
    return (lower ? "a" : "A") + v - 8'd10;
  endfunction

  function automatic logic [7:0] body_char();
    logic [7:0] c;
    do begin
      if ($urandom_range(0, 4) == 0) c = 8'($urandom_range(1, 255));
      else c = 8'($urandom_range(8'h20, 8'h7E));
    end while (c == CHAR_DOLLAR || c == CHAR_STAR);
    return c;
  endfunction

  task automatic push_checksum(input logic [7:0] sum, input digit_style_e style);
    logic [7:0] v;
    v = (style == DIG_WRONG) ? sum ^ 8'($urandom_range(1, 255)) : sum;
    if (style == DIG_ANY) begin
      byte_q.push_back(8'($urandom_range(0, 255)));
      byte_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      byte_q.push_back(hex_char(v[7:4], style == DIG_LOWER));
      byte_q.push_back(hex_char(v[3:0], style == DIG_LOWER));
    end
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) byte_q.push_back(s[i]);
  endtask

  task automatic push_sentence(input string s, input digit_style_e style);
    logic [7:0] sum;
    sum = 8'h00;
    byte_q.push_back(CHAR_DOLLAR);
    for (int i = 0; i < s.len(); i++) begin
      byte_q.push_back(s[i]);
      sum ^= s[i];
    end
    byte_q.push_back(CHAR_STAR);
    push_checksum(sum, style);
  endtask

  task automatic queue_random_sentence(inout int unsigned counted);
    int unsigned pick, k, start;
    logic [7:0]  sum, c;
    logic [55:0] letters;
    letters = "GPNRMCA";
    // line noise between sentences
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 4)) byte_q.push_back(8'($urandom_range(0, 255)));
    start = byte_q.size();
    // broken start, cut off by the next dollar
    if ($urandom_range(0, 9) == 0) begin
      byte_q.push_back(CHAR_DOLLAR);
      repeat ($urandom_range(0, 6)) byte_q.push_back(body_char());
    end
    byte_q.push_back(CHAR_DOLLAR);
    sum  = 8'h00;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      k = $urandom_range(0, 3);
      for (int i = 0; i < HdrLen; i++) begin
        c = header_char(k, i);
        byte_q.push_back(c);
        sum ^= c;
      end
    end else if (pick < 85) begin
      for (int i = 0; i < HdrLen; i++) begin
        c = letters[8*$urandom_range(0, 6) +: 8];
        byte_q.push_back(c);
        sum ^= c;
      end
    end else begin
      repeat ($urandom_range(0, 6)) begin
        c = body_char();
        byte_q.push_back(c);
        sum ^= c;
      end
    end
    repeat ($urandom_range(0, 10)) begin
      c = body_char();
      byte_q.push_back(c);
      sum ^= c;
    end
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      byte_q.push_back(CHAR_NUL);
    end else begin
      byte_q.push_back(CHAR_STAR);
      if (pick < 60)      push_checksum(sum, DIG_UPPER);
      else if (pick < 72) push_checksum(sum, DIG_LOWER);
      else if (pick < 84) push_checksum(sum, DIG_WRONG);
      else                push_checksum(sum, DIG_ANY);
    end
    counted += byte_q.size() - start;
  endtask

  initial begin : stim
    int unsigned counted;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    read_check(ADDR_GPS, 1'b1);
    read_check(ADDR_GLONASS, 1'b1);

    // directed: idle junk, GP GGA, restart into GN RMC with lower-case digits,
    // short header with dollar and NUL as digits, full header cut by NUL
    byte_q.push_back(8'hFF);
    byte_q.push_back("x");
    push_sentence("GPGGA", DIG_UPPER);
    push_text("$GN");
    push_sentence("GNRMC", DIG_LOWER);
    push_text("$G*$");
    byte_q.push_back(CHAR_NUL);
    push_text("$GPRMC,");
    byte_q.push_back(CHAR_NUL);
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      set_talkers(p[0], p[1]);
      if (p == 1) hold_request = 1'b1;
      counted = 0;
      while (counted < PHASE_WORDS) queue_random_sentence(counted);
      wait_drained();
    end

    $display("run covered %0d input words and %0d sentence results (%0d checksum matches, %0d cut short by NUL)",
             n_words, n_results, n_ok, n_early);
    $display("recognised %0d GGA and %0d RMC headers over all four talker enable settings",
             n_gga, n_rmc);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
